/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the NMEA sentence checker.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define NSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define NSC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hdl/nsc_pkg.sv */
// Package of the NMEA sentence checker: sizes, character codes, item types.
// No dependencies.
`default_nettype none
package nsc_pkg;

	localparam int MAX_LINE    = 128;
	localparam int CNT_W       = $clog2(MAX_LINE);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// type tags including the closing comma, first char at index 0
	localparam logic [7:0] RMC_TAG [6] = '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43, 8'h2C};
	localparam logic [7:0] GGA_TAG [6] = '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41, 8'h2C};

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_RMC   = 2'd1;
	localparam logic [1:0] KIND_GGA   = 2'd2;

	localparam logic [3:0] COMMA_MAX    = 4'd15;
	localparam logic [3:0] RMC_FIELD_AT = 4'd2;
	localparam logic [3:0] GGA_FIELD_AT = 4'd6;

	// classified byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       is_dollar;
		logic       is_nl;
		logic       is_star;
		logic       is_comma;
		logic       is_nul;
		logic       hex_valid;
		logic [3:0] hex_val;
		logic [5:0] rmc_eq;
		logic [5:0] gga_eq;
	} item_t;

	typedef struct packed {
		logic              full;
		logic              valid;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage
`default_nettype wire

/* hdl/nmea_sentence_checker.sv */
// Top level of the NMEA sentence checker: front end, item queue, back end.
// Depends on nsc_pkg, nsc_front, nsc_queue, nsc_back, assert_macros.svh.
//
// Usage:
//   Input channel (data_valid/data_ready/data_byte) takes one raw byte of an
//   NMEA stream per item. '$' opens a line; a newline in an open line closes
//   it and produces exactly one result item on the result channel
//   (result_valid/result_ready) carrying sentence_kind, checksum_ok,
//   has_fix and fix_code. Other bytes produce no result.
//   Throughput: one byte per cycle sustained while no result stall holds the
//   back end, which then retires one queued item per cycle.
//   A newline is first written into the queue; the back end then pops it
//   and loads the result register that drives the result channel.
//   Stall: while result_ready is low and a result is held, the back end
//   stops retiring; the two-entry queue then fills and data_ready drops.
//   data_ready depends only on queue occupancy, never on result_ready.
//   Reset (arst_n low): queue emptied, line closed, no result pending.
//   No clearing pass; the block takes items right after reset.
`default_nettype none
`include "assert_macros.svh"
module nmea_sentence_checker (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  logic       data_valid,
	output logic             data_ready,
	input  wire  logic [7:0] data_byte,
	output logic             result_valid,
	input  wire  logic       result_ready,
	output logic [1:0]       sentence_kind,
	output logic             checksum_ok,
	output logic             has_fix,
	output logic [7:0]       fix_code
);

	nsc_pkg::item_t     push_item;
	nsc_pkg::item_t     head;
	nsc_pkg::q_status_t q_stat;
	logic               push;
	logic               pop;

	// classify incoming bytes
	nsc_front u_front (
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	// decouples input acceptance from result stalls
	nsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// line tracking and result register
	nsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.head          (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.sentence_kind (sentence_kind),
		.checksum_ok   (checksum_ok),
		.has_fix       (has_fix),
		.fix_code      (fix_code)
	);

	`NSC_NEVER(a_q_overflow, clk, arst_n, q_stat.count > nsc_pkg::QCNT_W'(nsc_pkg::QUEUE_DEPTH), "queue count beyond depth")
	`NSC_NEVER(a_pop_empty, clk, arst_n, pop && !q_stat.valid, "pop from empty queue")
	`NSC_ASSERT(a_fix_needs_ok, clk, arst_n, result_valid && has_fix |-> checksum_ok && sentence_kind != nsc_pkg::KIND_OTHER, "fix without checksum or kind")
	`NSC_ASSERT(a_code_kind, clk, arst_n, result_valid && sentence_kind == nsc_pkg::KIND_OTHER |-> fix_code == 8'h00, "fix code set for unknown kind")

endmodule
`default_nettype wire

/* hdl/nsc_front.sv */
// Front end: takes raw bytes and classifies them into queue items.
// Depends on nsc_pkg.
`default_nettype none
module nsc_front (
	input  wire  logic               data_valid,
	output logic                     data_ready,
	input  wire  logic [7:0]         data_byte,
	input  wire  nsc_pkg::q_status_t q_stat,
	output logic                     push,
	output nsc_pkg::item_t           push_item
);

	always_comb begin
		nsc_pkg::item_t it;
		it           = '0;
		it.data      = data_byte;
		it.is_dollar = (data_byte == nsc_pkg::CH_DOLLAR);
		it.is_nl     = (data_byte == nsc_pkg::CH_NL);
		it.is_star   = (data_byte == nsc_pkg::CH_STAR);
		it.is_comma  = (data_byte == nsc_pkg::CH_COMMA);
		it.is_nul    = (data_byte == 8'h00);
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			it.hex_valid = 1'b1;
			it.hex_val   = data_byte[3:0];
		end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
				(data_byte >= 8'h41 && data_byte <= 8'h46)) begin
			it.hex_valid = 1'b1;
			it.hex_val   = data_byte[3:0] + 4'd9;
		end
		for (int i = 0; i < 6; i++) begin
			it.rmc_eq[i] = (data_byte == nsc_pkg::RMC_TAG[i]);
			it.gga_eq[i] = (data_byte == nsc_pkg::GGA_TAG[i]);
		end
		push_item = it;
	end

	assign data_ready = !q_stat.full;
	assign push       = data_valid && data_ready;

endmodule
`default_nettype wire

/* hdl/nsc_queue.sv */
// Short item queue between front and back end.
// Depends on nsc_pkg.
`default_nettype none
module nsc_queue (
	input  wire  logic           clk,
	input  wire  logic           arst_n,
	input  wire  logic           push,
	input  wire  nsc_pkg::item_t push_item,
	input  wire  logic           pop,
	output nsc_pkg::item_t       head,
	output nsc_pkg::q_status_t   q_stat
);

	nsc_pkg::item_t                mem_q [nsc_pkg::QUEUE_DEPTH];
	logic [nsc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [nsc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [nsc_pkg::QCNT_W-1:0]    count_q;

	function automatic logic [nsc_pkg::QPTR_W-1:0] ptr_inc(
			input logic [nsc_pkg::QPTR_W-1:0] p);
		if (p == nsc_pkg::QPTR_W'(nsc_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == nsc_pkg::QCNT_W'(nsc_pkg::QUEUE_DEPTH));
	assign q_stat.valid = (count_q != '0);
	assign q_stat.count = count_q;

endmodule
`default_nettype wire

/* hdl/nsc_back.sv */
// Back end: line state, checksum, kind and fix tracking, result register.
// Depends on nsc_pkg.
`default_nettype none
module nsc_back (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  nsc_pkg::q_status_t q_stat,
	input  wire  nsc_pkg::item_t     head,
	output logic                     pop,
	output logic                     result_valid,
	input  wire  logic               result_ready,
	output logic [1:0]               sentence_kind,
	output logic                     checksum_ok,
	output logic                     has_fix,
	output logic [7:0]               fix_code
);

	logic                     in_line_q;
	logic [nsc_pkg::CNT_W-1:0] stored_q;
	logic [7:0]               run_xor_q;
	logic [7:0]               star_xor_q;
	logic                     star_seen_q;
	logic [7:0]               recv_q;
	logic                     hex_open_q;
	logic                     text_end_q;
	logic [1:0]               kind_cand_q;
	logic [3:0]               comma_q;
	logic [7:0]               fchar_q;
	logic                     ffound_q;
	logic                     res_valid_q;

	logic                     n_in_line;
	logic [nsc_pkg::CNT_W-1:0] n_stored;
	logic [7:0]               n_run_xor;
	logic [7:0]               n_star_xor;
	logic                     n_star_seen;
	logic [7:0]               n_recv;
	logic                     n_hex_open;
	logic                     n_text_end;
	logic [1:0]               n_kind_cand;
	logic [3:0]               n_comma;
	logic [7:0]               n_fchar;
	logic                     n_ffound;
	logic                     emit;
	logic [1:0]               r_kind;
	logic                     r_ok;
	logic                     r_fix;
	logic [7:0]               r_code;

	assign pop = q_stat.valid && (!res_valid_q || result_ready);

	always_comb begin
		logic [nsc_pkg::CNT_W-1:0] pos;
		logic [2:0]               idx;
		logic [3:0]               target;
		logic                     rmc;
		logic                     gga;
		pos         = stored_q;
		idx         = '0;
		target      = '0;
		rmc         = 1'b0;
		gga         = 1'b0;
		n_in_line   = in_line_q;
		n_stored    = stored_q;
		n_run_xor   = run_xor_q;
		n_star_xor  = star_xor_q;
		n_star_seen = star_seen_q;
		n_recv      = recv_q;
		n_hex_open  = hex_open_q;
		n_text_end  = text_end_q;
		n_kind_cand = kind_cand_q;
		n_comma     = comma_q;
		n_fchar     = fchar_q;
		n_ffound    = ffound_q;
		emit        = 1'b0;
		r_kind      = nsc_pkg::KIND_OTHER;
		r_ok        = 1'b0;
		r_fix       = 1'b0;
		r_code      = '0;

		if (head.is_dollar) begin
			n_in_line = 1'b1;
			n_stored  = nsc_pkg::CNT_W'(1);
			n_run_xor = '0; n_star_xor = '0; n_star_seen = 1'b0; n_recv = '0;
			n_hex_open = 1'b0; n_text_end = 1'b0; n_kind_cand = 2'b11;
			n_comma = '0; n_fchar = '0; n_ffound = 1'b0;
		end else if (in_line_q) begin
			if (stored_q < nsc_pkg::CNT_W'(nsc_pkg::MAX_LINE - 1)) begin
				n_stored = stored_q + 1'b1;
				if (!text_end_q) begin
					// type tag at positions 1..6
					if (pos >= nsc_pkg::CNT_W'(1) && pos <= nsc_pkg::CNT_W'(6)) begin
						idx = 3'(pos - 1'b1);
						if (!head.rmc_eq[idx]) n_kind_cand[0] = 1'b0;
						if (!head.gga_eq[idx]) n_kind_cand[1] = 1'b0;
					end
					if (head.is_nul) begin
						n_text_end = 1'b1;
						n_hex_open = 1'b0;
					end else begin
						if (hex_open_q) begin
							if (head.hex_valid) n_recv = {recv_q[3:0], head.hex_val};
							else n_hex_open = 1'b0;
						end
						if (head.is_star) begin
							n_star_xor  = run_xor_q;
							n_star_seen = 1'b1;
							n_recv      = '0;
							n_hex_open  = 1'b1;
						end
						n_run_xor = run_xor_q ^ head.data;
						target = n_kind_cand[0] ? nsc_pkg::RMC_FIELD_AT
							: nsc_pkg::GGA_FIELD_AT;
						if (head.is_comma) begin
							if (comma_q < nsc_pkg::COMMA_MAX) n_comma = comma_q + 1'b1;
							if (n_comma == target) n_ffound = 1'b1;
						end else if (comma_q == target && fchar_q == 8'h00) begin
							n_fchar = head.data;
						end
					end
				end
			end
			if (head.is_nl) begin
				emit   = 1'b1;
				rmc    = n_kind_cand[0] && (n_stored >= nsc_pkg::CNT_W'(7));
				gga    = n_kind_cand[1] && (n_stored >= nsc_pkg::CNT_W'(7));
				r_kind = rmc ? nsc_pkg::KIND_RMC : (gga ? nsc_pkg::KIND_GGA
					: nsc_pkg::KIND_OTHER);
				r_ok   = n_star_seen && (n_star_xor == n_recv);
				r_code = ((rmc || gga) && n_ffound) ? n_fchar : 8'h00;
				if (r_ok && (rmc || gga) && n_ffound)
					r_fix = rmc ? (n_fchar == nsc_pkg::CH_A) : (n_fchar != nsc_pkg::CH_ZERO);
				n_in_line = 1'b0;
				n_stored  = '0;
				n_run_xor = '0; n_star_xor = '0; n_star_seen = 1'b0; n_recv = '0;
				n_hex_open = 1'b0; n_text_end = 1'b0; n_kind_cand = 2'b11;
				n_comma = '0; n_fchar = '0; n_ffound = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q   <= 1'b0;
			stored_q    <= '0;
			run_xor_q   <= '0;
			star_xor_q  <= '0;
			star_seen_q <= 1'b0;
			recv_q      <= '0;
			hex_open_q  <= 1'b0;
			text_end_q  <= 1'b0;
			kind_cand_q <= 2'b11;
			comma_q     <= '0;
			fchar_q     <= '0;
			ffound_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_line_q   <= n_in_line;
				stored_q    <= n_stored;
				run_xor_q   <= n_run_xor;
				star_xor_q  <= n_star_xor;
				star_seen_q <= n_star_seen;
				recv_q      <= n_recv;
				hex_open_q  <= n_hex_open;
				text_end_q  <= n_text_end;
				kind_cand_q <= n_kind_cand;
				comma_q     <= n_comma;
				fchar_q     <= n_fchar;
				ffound_q    <= n_ffound;
			end
			if (pop && emit) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with a new result only
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			sentence_kind <= r_kind;
			checksum_ok   <= r_ok;
			has_fix       <= r_fix;
			fix_code      <= r_code;
		end
	end

	assign result_valid = res_valid_q;

endmodule
`default_nettype wire
